/* rtl/bsq_pkg.sv */
// ----------------------------------------------------------------------------
// bsq_pkg
// Shared types, constants and helper functions for the byte store holding
// a stack and a circular queue.
// ----------------------------------------------------------------------------
package bsq_pkg;

	// Store geometry. The store size must be a power of two, so byte
	// addresses wrap by plain truncation.
	localparam int MEM_BYTES         = 256;
	localparam int MAX_ELEMENT_BYTES = 8;
	localparam int ADDR_W            = $clog2(MEM_BYTES);
	localparam int TOP_W             = ADDR_W + 1;
	localparam int SUM_W             = ADDR_W + 2;
	localparam int BIDX_W            = $clog2(MAX_ELEMENT_BYTES) > 0 ? $clog2(MAX_ELEMENT_BYTES) : 1;

	// Field widths of the interface.
	localparam int SIZE_W  = 4;
	localparam int OP_W    = 3;
	localparam int DATA_W  = 64;
	localparam int COUNT_W = 9;
	localparam int CIDX_W  = 1;

	// Configuration register indexes.
	localparam logic [CIDX_W-1:0] REG_STACK_SIZE = 1'b0;
	localparam logic [CIDX_W-1:0] REG_QUEUE_SIZE = 1'b1;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_PEEK    = 3'd2,
		OP_SCLEAR  = 3'd3,
		OP_ENQUEUE = 3'd4,
		OP_DEQUEUE = 3'd5
	} op_t;

	// Byte mover states.
	typedef enum logic [1:0] {
		MV_IDLE,
		MV_MOVE,
		MV_DRAIN,
		MV_FINISH
	} mv_state_t;

	// One memory job: a run of consecutive bytes to write or read.
	typedef struct packed {
		logic                has_bytes;
		logic                wr;
		logic [ADDR_W-1:0]   base;
		logic [BIDX_W-1:0]   last;
		logic [DATA_W-1:0]   wdata;
	} bsq_job_t;

	// Status that goes out with every result.
	typedef struct packed {
		logic               refused;
		logic [COUNT_W-1:0] stack_elements;
		logic [COUNT_W-1:0] queue_elements;
		logic               stack_is_empty;
		logic               queue_is_empty;
	} bsq_stat_t;

	// A size of zero acts as one, anything above the maximum as the maximum.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > SIZE_W'(MAX_ELEMENT_BYTES)) begin
			r = SIZE_W'(MAX_ELEMENT_BYTES);
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Store size modulo the element size, as a small constant table.
	function automatic logic [ADDR_W-1:0] mem_mod(input logic [SIZE_W-1:0] size);
		logic [ADDR_W-1:0] r;
		case (size)
			4'd1:    r = ADDR_W'(MEM_BYTES % 1);
			4'd2:    r = ADDR_W'(MEM_BYTES % 2);
			4'd3:    r = ADDR_W'(MEM_BYTES % 3);
			4'd4:    r = ADDR_W'(MEM_BYTES % 4);
			4'd5:    r = ADDR_W'(MEM_BYTES % 5);
			4'd6:    r = ADDR_W'(MEM_BYTES % 6);
			4'd7:    r = ADDR_W'(MEM_BYTES % 7);
			4'd8:    r = ADDR_W'(MEM_BYTES % 8);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

/* rtl/bsq_ram.sv */
// ----------------------------------------------------------------------------
// bsq_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module bsq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One access per cycle: a write, or a read whose data appears next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* rtl/bsq_ctrl.sv */
// ----------------------------------------------------------------------------
// bsq_ctrl
// Stack and queue pointers and counts. Decides each operation when it is
// accepted and hands the byte transfer to the mover.
// ----------------------------------------------------------------------------
module bsq_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [bsq_pkg::OP_W-1:0]      opcode,
	input  logic [bsq_pkg::DATA_W-1:0]    write_data,
	input  logic [bsq_pkg::SIZE_W-1:0]    stack_size,
	input  logic [bsq_pkg::SIZE_W-1:0]    queue_size,
	input  logic                          stack_cfg_wr,
	input  logic                          queue_cfg_wr,
	output bsq_pkg::bsq_job_t             job,
	output bsq_pkg::bsq_stat_t            stat
);

	logic [bsq_pkg::TOP_W-1:0]   stack_top_q, stack_top_d;
	logic [bsq_pkg::COUNT_W-1:0] stack_count_q, stack_count_d;
	logic [bsq_pkg::ADDR_W-1:0]  queue_head_q, queue_head_d;
	logic [bsq_pkg::ADDR_W-1:0]  queue_tail_q, queue_tail_d;
	logic [bsq_pkg::COUNT_W-1:0] queue_count_q, queue_count_d;
	logic                        refused_q, refused_d;

	logic [bsq_pkg::SUM_W-1:0]   push_end;
	logic [bsq_pkg::ADDR_W-1:0]  enq_probe;
	logic [bsq_pkg::TOP_W-1:0]   ss_top;
	logic [bsq_pkg::ADDR_W-1:0]  ss_addr;
	logic [bsq_pkg::ADDR_W-1:0]  qs_addr;

	assign ss_top    = bsq_pkg::TOP_W'(stack_size);
	assign ss_addr   = bsq_pkg::ADDR_W'(stack_size);
	assign qs_addr   = bsq_pkg::ADDR_W'(queue_size);
	assign push_end  = bsq_pkg::SUM_W'(stack_top_q) + bsq_pkg::SUM_W'(stack_size);
	assign enq_probe = queue_tail_q + bsq_pkg::mem_mod(queue_size) + qs_addr;

	// Operation decode: refusal, next pointers and the byte job.
	always_comb begin
		stack_top_d   = stack_top_q;
		stack_count_d = stack_count_q;
		queue_head_d  = queue_head_q;
		queue_tail_d  = queue_tail_q;
		queue_count_d = queue_count_q;
		refused_d     = 1'b0;
		job           = '0;
		job.wdata     = write_data;
		case (bsq_pkg::op_t'(opcode))
			bsq_pkg::OP_PUSH: begin
				if (push_end > bsq_pkg::SUM_W'(bsq_pkg::MEM_BYTES)) begin
					refused_d = 1'b1;
				end else begin
					job.has_bytes = 1'b1;
					job.wr        = 1'b1;
					job.base      = stack_top_q[bsq_pkg::ADDR_W-1:0];
					job.last      = bsq_pkg::BIDX_W'(stack_size - bsq_pkg::SIZE_W'(1));
					stack_top_d   = stack_top_q + ss_top;
					stack_count_d = stack_count_q + bsq_pkg::COUNT_W'(1);
				end
			end
			bsq_pkg::OP_POP, bsq_pkg::OP_PEEK: begin
				if (stack_top_q == '0) begin
					refused_d = 1'b1;
				end else begin
					job.has_bytes = 1'b1;
					job.base      = stack_top_q[bsq_pkg::ADDR_W-1:0] - ss_addr;
					job.last      = bsq_pkg::BIDX_W'(stack_size - bsq_pkg::SIZE_W'(1));
					if (bsq_pkg::op_t'(opcode) == bsq_pkg::OP_POP) begin
						stack_top_d = (stack_top_q >= ss_top) ? stack_top_q - ss_top : '0;
						if (stack_count_q != '0) begin
							stack_count_d = stack_count_q - bsq_pkg::COUNT_W'(1);
						end
					end
				end
			end
			bsq_pkg::OP_SCLEAR: begin
				stack_top_d   = '0;
				stack_count_d = '0;
			end
			bsq_pkg::OP_ENQUEUE: begin
				if (enq_probe == queue_head_q) begin
					refused_d = 1'b1;
				end else begin
					job.has_bytes = 1'b1;
					job.wr        = 1'b1;
					job.base      = queue_tail_q;
					job.last      = bsq_pkg::BIDX_W'(queue_size - bsq_pkg::SIZE_W'(1));
					queue_tail_d  = queue_tail_q + qs_addr;
					queue_count_d = queue_count_q + bsq_pkg::COUNT_W'(1);
				end
			end
			bsq_pkg::OP_DEQUEUE: begin
				if (queue_tail_q == queue_head_q) begin
					refused_d = 1'b1;
				end else begin
					job.has_bytes = 1'b1;
					job.base      = queue_head_q;
					job.last      = bsq_pkg::BIDX_W'(queue_size - bsq_pkg::SIZE_W'(1));
					queue_head_d  = queue_head_q + qs_addr;
					if (queue_count_q != '0) begin
						queue_count_d = queue_count_q - bsq_pkg::COUNT_W'(1);
					end
				end
			end
			default: begin
				refused_d = 1'b1;
			end
		endcase
	end

	// Pointer state. A size write clears its structure.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_top_q   <= '0;
			stack_count_q <= '0;
			queue_head_q  <= '0;
			queue_tail_q  <= '0;
			queue_count_q <= '0;
			refused_q     <= 1'b0;
		end else if (go) begin
			stack_top_q   <= stack_top_d;
			stack_count_q <= stack_count_d;
			queue_head_q  <= queue_head_d;
			queue_tail_q  <= queue_tail_d;
			queue_count_q <= queue_count_d;
			refused_q     <= refused_d;
		end else begin
			if (stack_cfg_wr) begin
				stack_top_q   <= '0;
				stack_count_q <= '0;
			end
			if (queue_cfg_wr) begin
				queue_head_q  <= '0;
				queue_tail_q  <= '0;
				queue_count_q <= '0;
			end
		end
	end

	// Status reflects the state left by the last accepted item.
	always_comb begin
		stat.refused        = refused_q;
		stat.stack_elements = stack_count_q;
		stat.queue_elements = queue_count_q;
		stat.stack_is_empty = (stack_top_q == '0);
		stat.queue_is_empty = (queue_tail_q == queue_head_q);
	end

endmodule

/* rtl/bsq_mover.sv */
// ----------------------------------------------------------------------------
// bsq_mover
// Moves the bytes of one element between the data word and the byte RAM,
// one byte per cycle, and assembles read data little-endian.
// ----------------------------------------------------------------------------
module bsq_mover (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  bsq_pkg::bsq_job_t             job,
	output logic                          busy,
	output logic                          done,
	output logic [bsq_pkg::DATA_W-1:0]    read_data
);

	bsq_pkg::mv_state_t state_q, state_d;

	logic [bsq_pkg::ADDR_W-1:0] base_q;
	logic [bsq_pkg::BIDX_W-1:0] last_q;
	logic [bsq_pkg::BIDX_W-1:0] idx_q;
	logic                       wr_q;
	logic [bsq_pkg::DATA_W-1:0] wdata_q;
	logic [bsq_pkg::DATA_W-1:0] rdata_q;
	logic                       rd_s1;
	logic [bsq_pkg::BIDX_W-1:0] idx_s1;

	logic                       ram_en;
	logic                       ram_we;
	logic [bsq_pkg::ADDR_W-1:0] ram_addr;
	logic [7:0]                 ram_wdata;
	logic [7:0]                 ram_rdata;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bsq_pkg::MV_IDLE, bsq_pkg::MV_FINISH: begin
				if (go) begin
					state_d = job.has_bytes ? bsq_pkg::MV_MOVE : bsq_pkg::MV_FINISH;
				end else begin
					state_d = bsq_pkg::MV_IDLE;
				end
			end
			bsq_pkg::MV_MOVE: begin
				if (idx_q == last_q) begin
					state_d = bsq_pkg::MV_DRAIN;
				end
			end
			bsq_pkg::MV_DRAIN: begin
				state_d = bsq_pkg::MV_FINISH;
			end
			default: begin
				state_d = bsq_pkg::MV_IDLE;
			end
		endcase
	end

	// State outputs.
	always_comb begin
		busy   = 1'b0;
		done   = 1'b0;
		ram_en = 1'b0;
		case (state_q)
			bsq_pkg::MV_MOVE: begin
				busy   = 1'b1;
				ram_en = 1'b1;
			end
			bsq_pkg::MV_DRAIN: begin
				busy = 1'b1;
			end
			bsq_pkg::MV_FINISH: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bsq_pkg::MV_IDLE;
			rd_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= ram_en && !wr_q;
		end
	end

	// Job registers and the byte counter.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (go) begin
			base_q  <= job.base;
			last_q  <= job.last;
			wr_q    <= job.wr;
			wdata_q <= job.wdata;
			idx_q   <= '0;
			rdata_q <= '0;
		end else begin
			if (ram_en) begin
				idx_q <= idx_q + bsq_pkg::BIDX_W'(1);
			end
			// Read data returns in the cycle after its address.
			if (rd_s1) begin
				rdata_q[idx_s1*8 +: 8] <= ram_rdata;
			end
		end
	end

	// Addresses wrap around the end of the store.
	assign ram_we    = ram_en && wr_q;
	assign ram_addr  = base_q + bsq_pkg::ADDR_W'(idx_q);
	assign ram_wdata = wdata_q[idx_q*8 +: 8];
	assign read_data = rdata_q;

	bsq_ram #(
		.WIDTH (8),
		.DEPTH (bsq_pkg::MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/byte_store_stack_and_queue_top.sv */
// ----------------------------------------------------------------------------
// byte_store_stack_and_queue_top
// A stack and a circular queue sharing one byte-wide store.
// ----------------------------------------------------------------------------
// Usage:
// Commands enter on start/opcode/write_data and are taken at a clock edge
// where start is high and busy is low. Every command gives one result,
// shown for exactly one cycle while done is high: read_data, status and
// both element counts and empty flags after the command.
// Element sizes are set through the cfg_valid/cfg_ready channel (index 0
// stack size, index 1 queue size); a write clears that structure. Only
// write them while no command is in flight.
// Sequence: push, pop, peek, enqueue and dequeue move their N bytes through
// the single-port byte RAM one per cycle, then pass a drain state before
// done rises, and the next command can be taken at the edge that ends the
// done cycle. Refused, stack clear and unused commands skip the byte
// transfer and go straight to the done state.
// Reset clears all pointers and counts and sets both sizes to one byte;
// the store content is undefined until written. The receiver cannot stall:
// a result is lost if it is not taken in its done cycle.
// ----------------------------------------------------------------------------
module byte_store_stack_and_queue_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bsq_pkg::OP_W-1:0]      opcode,
	input  logic [bsq_pkg::DATA_W-1:0]    write_data,
	output logic                          done,
	output logic [bsq_pkg::DATA_W-1:0]    read_data,
	output logic                          status,
	output logic [bsq_pkg::COUNT_W-1:0]   stack_elements,
	output logic [bsq_pkg::COUNT_W-1:0]   queue_elements,
	output logic                          stack_is_empty,
	output logic                          queue_is_empty,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsq_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [bsq_pkg::SIZE_W-1:0]    cfg_data
);

	logic [bsq_pkg::SIZE_W-1:0] stack_size_q;
	logic [bsq_pkg::SIZE_W-1:0] queue_size_q;
	logic                       cfg_xfer;
	logic                       stack_cfg_wr;
	logic                       queue_cfg_wr;
	logic                       go;
	bsq_pkg::bsq_job_t          job;
	bsq_pkg::bsq_stat_t         stat;

	// Command and configuration transfers. A size write waits while a
	// command is being offered, so the two never share an edge.
	assign go           = start && !busy;
	assign cfg_ready    = !busy && !start;
	assign cfg_xfer     = cfg_valid && cfg_ready;
	assign stack_cfg_wr = cfg_xfer && (cfg_index == bsq_pkg::REG_STACK_SIZE);
	assign queue_cfg_wr = cfg_xfer && (cfg_index == bsq_pkg::REG_QUEUE_SIZE);

	// Element size registers, kept in their clamped form.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_size_q <= bsq_pkg::SIZE_W'(1);
			queue_size_q <= bsq_pkg::SIZE_W'(1);
		end else begin
			if (stack_cfg_wr) begin
				stack_size_q <= bsq_pkg::clamp_size(cfg_data);
			end
			if (queue_cfg_wr) begin
				queue_size_q <= bsq_pkg::clamp_size(cfg_data);
			end
		end
	end

	bsq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (go),
		.opcode       (opcode),
		.write_data   (write_data),
		.stack_size   (stack_size_q),
		.queue_size   (queue_size_q),
		.stack_cfg_wr (stack_cfg_wr),
		.queue_cfg_wr (queue_cfg_wr),
		.job          (job),
		.stat         (stat)
	);

	bsq_mover u_mover (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.job       (job),
		.busy      (busy),
		.done      (done),
		.read_data (read_data)
	);

	// Result status fields.
	assign status         = stat.refused;
	assign stack_elements = stat.stack_elements;
	assign queue_elements = stat.queue_elements;
	assign stack_is_empty = stat.stack_is_empty;
	assign queue_is_empty = stat.queue_is_empty;

endmodule
